/* rtl/kare_pkg.sv */
package kare_pkg;

    localparam int unsigned KEY_W   = 12;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned DIR_N   = 4;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned EVENT_W = 6;
    localparam int unsigned HOLD_W  = 4;

    localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd300;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd100;

    typedef enum logic
    {
        REG_REPEAT_DELAY    = 1'b0,
        REG_REPEAT_INTERVAL = 1'b1
    } cfg_reg_t;

    localparam int unsigned KEY_CTRL      = 4;
    localparam int unsigned KEY_Z         = 5;
    localparam int unsigned KEY_ALT       = 6;
    localparam int unsigned KEY_ENTER     = 7;
    localparam int unsigned KEY_SHIFT     = 8;
    localparam int unsigned KEY_SPACE     = 9;
    localparam int unsigned KEY_M         = 10;
    localparam int unsigned KEY_SEMICOLON = 11;

    localparam int unsigned EV_ACT_RELEASE = 0;
    localparam int unsigned EV_FLG_RELEASE = 1;
    localparam int unsigned EV_CONFIRM     = 2;
    localparam int unsigned EV_HYPOTHESIS  = 3;
    localparam int unsigned EV_POINTER     = 4;
    localparam int unsigned EV_MUSIC       = 5;

    localparam int unsigned HOLD_ACT = 0;
    localparam int unsigned HOLD_FLG = 1;
    localparam int unsigned CANC_ACT = 2;
    localparam int unsigned CANC_FLG = 3;

    typedef struct packed
    {
        logic [EVENT_W-1:0] event_pulses;
        logic [HOLD_W-1:0]  hold_status;
    } btn_result_t;

endpackage

/* rtl/key_autorepeat_and_press_events_core.sv */
// Pipeline: a poll that is taken is held in the input register, and its result is registered
// in the result register that drives out_valid; out_stall can hold it in either register.
// Throughput: one poll per cycle while in_stall is low; the result register holds while out_stall
// is high, and in_stall rises as soon as the input register also holds a poll.
// Reset: rst_n clears all key state and the pipeline valids at once and loads the
// repeat delay and interval with their defaults of 300 ms and 100 ms.
module key_autorepeat_and_press_events_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [kare_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [kare_pkg::KEY_W-1:0]    key_levels,
    input  logic [kare_pkg::TIME_W-1:0]   now_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kare_pkg::DIR_N-1:0]    direction_pulses,
    output logic [kare_pkg::EVENT_W-1:0]  event_pulses,
    output logic [kare_pkg::HOLD_W-1:0]   hold_status
);

    logic [kare_pkg::CFG_W-1:0]   delay_reg;
    logic [kare_pkg::CFG_W-1:0]   interval_reg;
    logic                         s1_valid_reg;
    logic [kare_pkg::KEY_W-1:0]   s1_keys_reg;
    logic [kare_pkg::TIME_W-1:0]  s1_now_reg;
    logic                         out_valid_reg;
    logic [kare_pkg::DIR_N-1:0]   dir_reg;
    logic [kare_pkg::EVENT_W-1:0] event_reg;
    logic [kare_pkg::HOLD_W-1:0]  hold_reg;
    logic                         out_free;
    logic                         commit;
    logic                         in_take;
    logic [kare_pkg::DIR_N-1:0]   dir_pulses;
    kare_pkg::btn_result_t        btn_result;

    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= kare_pkg::DELAY_RESET;
            interval_reg <= kare_pkg::INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (kare_pkg::cfg_reg_t'(cfg_index))
                kare_pkg::REG_REPEAT_DELAY:    delay_reg    <= cfg_data;
                kare_pkg::REG_REPEAT_INTERVAL: interval_reg <= cfg_data;
                default:                       delay_reg    <= delay_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take || commit)
            begin
                s1_valid_reg <= in_take;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_keys_reg <= key_levels;
            s1_now_reg  <= now_ms;
        end
        if (commit)
        begin
            dir_reg   <= dir_pulses;
            event_reg <= btn_result.event_pulses;
            hold_reg  <= btn_result.hold_status;
        end
    end

    kare_dir_unit u_dir
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .commit          (commit),
        .dir_keys        (s1_keys_reg[kare_pkg::DIR_N-1:0]),
        .now_ms          (s1_now_reg),
        .repeat_delay    (delay_reg),
        .repeat_interval (interval_reg),
        .pulses          (dir_pulses)
    );

    kare_button_unit u_button
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .keys   (s1_keys_reg),
        .result (btn_result)
    );

    assign out_valid        = out_valid_reg;
    assign direction_pulses = dir_reg;
    assign event_pulses     = event_reg;
    assign hold_status      = hold_reg;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled without a waiting item");

    a_hold_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hold_status[kare_pkg::HOLD_ACT] && hold_status[kare_pkg::HOLD_FLG]))
        else $error("action and flag held together");

    a_pulse_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (direction_pulses & ~$past(s1_keys_reg[kare_pkg::DIR_N-1:0])) == '0)
        else $error("direction pulse on a released key");
`endif

endmodule

/* rtl/kare_dir_unit.sv */
module kare_dir_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                commit,
    input  logic [kare_pkg::DIR_N-1:0]          dir_keys,
    input  logic [kare_pkg::TIME_W-1:0]         now_ms,
    input  logic [kare_pkg::CFG_W-1:0]          repeat_delay,
    input  logic [kare_pkg::CFG_W-1:0]          repeat_interval,
    output logic [kare_pkg::DIR_N-1:0]          pulses
);

    logic [kare_pkg::DIR_N-1:0]  latches_reg, latches_next;
    logic [kare_pkg::DIR_W-1:0]  last_reg, last_next;
    logic                        repeating_reg, repeating_next;
    logic [kare_pkg::TIME_W-1:0] start_reg, start_next;
    logic [kare_pkg::TIME_W-1:0] elapsed;
    logic [kare_pkg::CFG_W-1:0]  threshold;
    logic                        expired;

    // Only the direction pressed last before this poll, if still held, can repeat, so one compare
    // against the stored start time serves all four keys.
    assign elapsed   = now_ms - start_reg;
    assign threshold = repeating_reg ? repeat_interval : repeat_delay;
    assign expired   = elapsed > {{(kare_pkg::TIME_W-kare_pkg::CFG_W){1'b0}}, threshold};

    always_comb
    begin
        latches_next   = latches_reg;
        last_next      = last_reg;
        repeating_next = repeating_reg;
        start_next     = start_reg;
        pulses         = '0;
        for (int d = 0; d < kare_pkg::DIR_N; d++)
        begin
            if (dir_keys[d])
            begin
                if (!latches_reg[d])
                begin
                    pulses[d]       = 1'b1;
                    latches_next[d] = 1'b1;
                    last_next       = kare_pkg::DIR_W'(d);
                    repeating_next  = 1'b0;
                    start_next      = now_ms;
                end
                else if (last_next == kare_pkg::DIR_W'(d) && expired)
                begin
                    pulses[d]      = 1'b1;
                    repeating_next = 1'b1;
                    start_next     = now_ms;
                end
            end
            else
            begin
                latches_next[d] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latches_reg   <= '0;
            last_reg      <= '0;
            repeating_reg <= 1'b0;
            start_reg     <= '0;
        end
        else if (commit)
        begin
            latches_reg   <= latches_next;
            last_reg      <= last_next;
            repeating_reg <= repeating_next;
            start_reg     <= start_next;
        end
    end

endmodule

/* rtl/kare_button_unit.sv */
module kare_button_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        commit,
    input  logic [kare_pkg::KEY_W-1:0]  keys,
    output kare_pkg::btn_result_t       result
);

    logic [kare_pkg::HOLD_W-1:0] modes_reg, modes_next;
    logic                        busy_reg, busy_next;
    logic [3:0]                  edge_reg, edge_next;
    logic [3:0]                  levels;

    assign levels[0] = keys[kare_pkg::KEY_CTRL] | keys[kare_pkg::KEY_ENTER];
    assign levels[1] = keys[kare_pkg::KEY_SHIFT];
    assign levels[2] = keys[kare_pkg::KEY_SPACE];
    assign levels[3] = keys[kare_pkg::KEY_M] | keys[kare_pkg::KEY_SEMICOLON];
    assign edge_next = levels;

    always_comb
    begin
        logic act;
        logic flg;
        logic ha;
        logic hf;
        logic ca;
        logic cf;
        logic busy;
        logic [kare_pkg::EVENT_W-1:0] ev;

        act  = keys[kare_pkg::KEY_CTRL] | keys[kare_pkg::KEY_Z];
        flg  = keys[kare_pkg::KEY_ALT];
        ha   = modes_reg[kare_pkg::HOLD_ACT];
        hf   = modes_reg[kare_pkg::HOLD_FLG];
        ca   = modes_reg[kare_pkg::CANC_ACT];
        cf   = modes_reg[kare_pkg::CANC_FLG];
        busy = busy_reg;
        ev   = '0;

        if (act && !ha && !hf && !busy)
        begin
            ha   = 1'b1;
            busy = 1'b1;
        end
        if (!act && ha)
        begin
            ha = 1'b0;
            ev[kare_pkg::EV_ACT_RELEASE] = 1'b1;
            busy = 1'b0;
        end
        if (flg && !ha && !hf && !busy)
        begin
            hf   = 1'b1;
            busy = 1'b1;
        end
        if (!flg && hf)
        begin
            hf = 1'b0;
            ev[kare_pkg::EV_FLG_RELEASE] = 1'b1;
            busy = 1'b0;
        end
        if (flg && ha && !hf)
        begin
            ha   = 1'b0;
            ca   = 1'b1;
            busy = 1'b1;
        end
        if (!flg && !act && ca)
        begin
            ca   = 1'b0;
            busy = 1'b0;
        end
        if (act && !ha && hf)
        begin
            hf   = 1'b0;
            cf   = 1'b1;
            busy = 1'b1;
        end
        if (!flg && !act && cf)
        begin
            cf   = 1'b0;
            busy = 1'b0;
        end

        ev[kare_pkg::EV_CONFIRM]    = levels[0] & ~edge_reg[0];
        ev[kare_pkg::EV_HYPOTHESIS] = levels[1] & ~edge_reg[1];
        ev[kare_pkg::EV_POINTER]    = levels[2] & ~edge_reg[2];
        ev[kare_pkg::EV_MUSIC]      = levels[3] & ~edge_reg[3];

        modes_next = '0;
        modes_next[kare_pkg::HOLD_ACT] = ha;
        modes_next[kare_pkg::HOLD_FLG] = hf;
        modes_next[kare_pkg::CANC_ACT] = ca;
        modes_next[kare_pkg::CANC_FLG] = cf;
        busy_next = busy;

        result.event_pulses = ev;
        result.hold_status  = modes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg <= '0;
            busy_reg  <= 1'b0;
            edge_reg  <= '0;
        end
        else if (commit)
        begin
            modes_reg <= modes_next;
            busy_reg  <= busy_next;
            edge_reg  <= edge_next;
        end
    end

endmodule
